// ===== sv/shc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI HCI host sequencer package
// Shared item and result types and the event, phase and command codes.
// ----------------------------------------------------------------------------
package shc_pkg;

	// Event codes carried by the mode field of an input item.
	typedef enum logic [2:0] {
		MODE_POLL     = 3'd0,
		MODE_CMD_DONE = 3'd1,
		MODE_RX_BYTE  = 3'd2,
		MODE_DATA_END = 3'd3,
		MODE_HOST_TX  = 3'd4,
		MODE_HOST_RX  = 3'd5
	} mode_t;

	// Transaction phase.
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_RX_CMD  = 3'd1,
		PH_RX_DATA = 3'd2,
		PH_TX_RDY  = 3'd3,
		PH_TX_CMD  = 3'd4,
		PH_TX_DATA = 3'd5
	} phase_t;

	// Bus action requested for this step.
	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_READ  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_RX    = 3'd3,
		CMD_TX    = 3'd4
	} cmd_t;

	// Slave status byte that means the slave is ready.
	localparam logic [7:0] STS_READY = 8'hC0;
	// Command bytes sent on the bus outside this block.
	localparam logic [7:0] SPI_READ_OPCODE  = 8'h81;
	localparam logic [7:0] SPI_WRITE_OPCODE = 8'h42;

	typedef struct packed {
		mode_t       mode;
		logic        rdy;
		logic [7:0]  sts_first;
		logic [7:0]  sts_second;
		logic [7:0]  data_byte;
		logic [15:0] length;
	} item_t;

	typedef struct packed {
		logic       cs_n;
		cmd_t       spi_cmd;
		logic [7:0] xfer_len;
		logic [7:0] host_byte;
		logic       host_byte_valid;
		logic       rx_done;
		logic       tx_done;
		phase_t     phase;
	} result_t;

endpackage

// ===== sv/shc_item_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input event channel
// Valid/ready channel that carries one sequencer event per transfer.
// ----------------------------------------------------------------------------
interface shc_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic        rdy;
	logic [7:0]  sts_first;
	logic [7:0]  sts_second;
	logic [7:0]  data_byte;
	logic [15:0] length;

	modport source (
		output valid, mode, rdy, sts_first, sts_second, data_byte, length,
		input  ready
	);
	modport sink (
		input  valid, mode, rdy, sts_first, sts_second, data_byte, length,
		output ready
	);
endinterface

// ===== sv/shc_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one sequencer result per transfer.
// ----------------------------------------------------------------------------
interface shc_result_if;
	logic       valid;
	logic       ready;
	logic       cs_n;
	logic [2:0] spi_cmd;
	logic [7:0] xfer_len;
	logic [7:0] host_byte;
	logic       host_byte_valid;
	logic       rx_done;
	logic       tx_done;
	logic [2:0] phase;

	modport source (
		output valid, cs_n, spi_cmd, xfer_len, host_byte, host_byte_valid,
		       rx_done, tx_done, phase,
		input  ready
	);
	modport sink (
		input  valid, cs_n, spi_cmd, xfer_len, host_byte, host_byte_valid,
		       rx_done, tx_done, phase,
		output ready
	);
endinterface

// ===== sv/shc_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive ring memory
// Byte memory with one write port and one registered read port. The read
// port prefetches the entry at the next tail, with write-to-read forwarding.
// ----------------------------------------------------------------------------
module shc_ring #(
	parameter int DEPTH = 128,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, forwarding a byte written to the same entry this cycle.
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== sv/shc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer step logic
// Holds the transaction state and computes one step per registered event:
// host pop from the ring, then the event itself.
// ----------------------------------------------------------------------------
module shc_ctrl #(
	parameter int RING_DEPTH = 128,
	parameter int RX_CHUNK   = 64,
	parameter int AW         = $clog2(RING_DEPTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  shc_pkg::item_t  item,
	input  logic [7:0]      rd_data,
	output shc_pkg::result_t result,
	output logic            wr_en,
	output logic [AW-1:0]   wr_addr,
	output logic [7:0]      wr_data,
	output logic [AW-1:0]   rd_addr
);
	import shc_pkg::*;

	localparam int FW = $clog2(RING_DEPTH + 1);
	// Largest fill level that still leaves room for a full read chunk.
	localparam int RD_ROOM = RING_DEPTH - RX_CHUNK;
	localparam logic [7:0] CHUNK_MAX = 8'(RX_CHUNK);
	localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
	localparam logic [FW-1:0] FILL_FULL = FW'(RING_DEPTH);

	phase_t        phase_q, phase_d;
	logic          cs_q, cs_d;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [7:0]    rx_len_q, rx_len_d;
	logic [7:0]    rx_got_q, rx_got_d;
	logic [15:0]   tx_rem_q, tx_rem_d;
	logic [7:0]    tx_len_q, tx_len_d;
	logic [15:0]   want_q, want_d;

	logic [15:0]   want_cur;
	logic          pop;
	logic [FW-1:0] fill_p;
	logic          do_poll;
	logic [15:0]   tx_left;

	// Step logic: host pop first, then the event.
	always_comb begin
		phase_d  = phase_q;
		cs_d     = cs_q;
		head_d   = head_q;
		tail_d   = tail_q;
		rx_len_d = rx_len_q;
		rx_got_d = rx_got_q;
		tx_rem_d = tx_rem_q;
		tx_len_d = tx_len_q;
		wr_en    = 1'b0;
		do_poll  = 1'b0;
		tx_left  = 16'd0;
		result   = '0;
		result.spi_cmd = CMD_NONE;

		// Host receive request and byte delivery.
		want_cur = (item.mode == MODE_HOST_RX) ? item.length : want_q;
		pop      = (want_cur != 16'd0) && (fill_q != '0);
		want_d   = want_cur - {15'd0, pop};
		fill_p   = fill_q - {{(FW-1){1'b0}}, pop};
		if (pop) begin
			tail_d = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
			result.host_byte       = rd_data;
			result.host_byte_valid = 1'b1;
			result.rx_done         = (want_cur == 16'd1);
		end
		fill_d = fill_p;

		case (item.mode)
			MODE_POLL, MODE_HOST_RX: begin
				do_poll = 1'b1;
			end
			MODE_HOST_TX: begin
				tx_rem_d = item.length;
				do_poll  = 1'b1;
			end
			MODE_CMD_DONE: begin
				if (phase_q == PH_RX_CMD) begin
					if (item.sts_first != STS_READY) begin
						cs_d    = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						rx_len_d = (item.sts_second < CHUNK_MAX) ? item.sts_second : CHUNK_MAX;
						rx_got_d = 8'd0;
						result.spi_cmd  = CMD_RX;
						result.xfer_len = rx_len_d;
						phase_d = PH_RX_DATA;
					end
				end else if (phase_q == PH_TX_CMD) begin
					if ((item.sts_first != STS_READY) || (item.sts_second == 8'd0)) begin
						cs_d    = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						tx_len_d = (tx_rem_q < {8'd0, item.sts_second}) ?
							tx_rem_q[7:0] : item.sts_second;
						result.spi_cmd  = CMD_TX;
						result.xfer_len = tx_len_d;
						phase_d = PH_TX_DATA;
					end
				end
			end
			MODE_RX_BYTE: begin
				if ((phase_q == PH_RX_DATA) && (rx_got_q < rx_len_q) &&
				    (fill_p < FILL_FULL)) begin
					wr_en    = 1'b1;
					head_d   = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
					fill_d   = fill_p + 1'b1;
					rx_got_d = rx_got_q + 8'd1;
				end
			end
			MODE_DATA_END: begin
				if (phase_q == PH_RX_DATA) begin
					cs_d     = 1'b1;
					phase_d  = PH_IDLE;
					rx_len_d = 8'd0;
					rx_got_d = 8'd0;
				end else if (phase_q == PH_TX_DATA) begin
					tx_left  = (tx_rem_q > {8'd0, tx_len_q}) ?
						tx_rem_q - {8'd0, tx_len_q} : 16'd0;
					tx_rem_d = tx_left;
					tx_len_d = 8'd0;
					if (tx_left != 16'd0) begin
						cs_d    = 1'b0;
						phase_d = PH_TX_RDY;
					end else begin
						cs_d    = 1'b1;
						phase_d = PH_IDLE;
						result.tx_done = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		// Poll: start a read when there is room, else a pending write.
		if (do_poll) begin
			if (phase_q == PH_IDLE) begin
				if (item.rdy && (int'(fill_p) <= RD_ROOM)) begin
					cs_d    = 1'b0;
					phase_d = PH_RX_CMD;
					result.spi_cmd = CMD_READ;
				end else if (tx_rem_d != 16'd0) begin
					cs_d    = 1'b0;
					phase_d = PH_TX_RDY;
				end
			end else if (phase_q == PH_TX_RDY) begin
				if (item.rdy) begin
					phase_d = PH_TX_CMD;
					result.spi_cmd = CMD_WRITE;
				end
			end
		end

		result.cs_n  = cs_d;
		result.phase = phase_d;
	end

	assign wr_addr = head_q;
	assign wr_data = item.data_byte;
	// Prefetch the entry that will be at the tail for the next step.
	assign rd_addr = step ? tail_d : tail_q;

	// State registers, updated only when a step runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cs_q     <= 1'b1;
			head_q   <= '0;
			tail_q   <= '0;
			fill_q   <= '0;
			rx_len_q <= 8'd0;
			rx_got_q <= 8'd0;
			tx_rem_q <= 16'd0;
			tx_len_q <= 8'd0;
			want_q   <= 16'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			cs_q     <= cs_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			fill_q   <= fill_d;
			rx_len_q <= rx_len_d;
			rx_got_q <= rx_got_d;
			tx_rem_q <= tx_rem_d;
			tx_len_q <= tx_len_d;
			want_q   <= want_d;
		end
	end

	// The ring never holds more bytes than it has entries.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("ring fill exceeds depth");

	// Chip select is released exactly when the sequencer is idle.
	a_cs_phase: assert property (@(posedge clk) disable iff (!arst_n)
		cs_q == (phase_q == PH_IDLE))
		else $error("chip select disagrees with phase");

	// A read chunk never takes more bytes than its length.
	a_chunk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_got_q <= rx_len_q)
		else $error("read chunk overrun");

	// Ring pointers move only when a step runs.
	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(tail_q) && $stable(head_q)))
		else $error("ring pointer moved without a step");

endmodule

// ===== sv/spi_hci_host_transaction_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI HCI host transaction controller
// Sequences SPI read and write transactions with an HCI slave, buffers
// received bytes in a ring and hands them to the host one per event.
// ----------------------------------------------------------------------------
// Flow: an accepted event lands in the input register, its step runs once the
// result register is free or its result is being taken, and its result is then
// registered in the result register and offered.
// Throughput: one event per cycle while results are taken; the step logic and
// the ring's single registered read port, prefetching the next tail entry, set it.
// Reset: arst_n clears all control state to idle with chip select released;
// ring contents are not cleared and no clearing pass is needed.
module spi_hci_host_transaction_controller #(
	parameter int RING_DEPTH = 128,
	parameter int RX_CHUNK   = 64
) (
	input logic           clk,
	input logic           arst_n,
	shc_item_if.sink      in_ch,
	shc_result_if.source  out_ch
);
	import shc_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);

	logic          valid_s1;
	item_t         item_s1;
	logic          out_valid_q;
	result_t       result_q;
	result_t       result_d;
	logic          step;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	// A step runs when an event is held and the result register is free or being read.
	assign step        = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.mode       <= mode_t'(in_ch.mode);
			item_s1.rdy        <= in_ch.rdy;
			item_s1.sts_first  <= in_ch.sts_first;
			item_s1.sts_second <= in_ch.sts_second;
			item_s1.data_byte  <= in_ch.data_byte;
			item_s1.length     <= in_ch.length;
		end
	end

	shc_ring #(
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en && step),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	shc_ctrl #(
		.RING_DEPTH (RING_DEPTH),
		.RX_CHUNK   (RX_CHUNK)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item    (item_s1),
		.rd_data (rd_data),
		.result  (result_d),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result_d;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.cs_n            = result_q.cs_n;
	assign out_ch.spi_cmd         = result_q.spi_cmd;
	assign out_ch.xfer_len        = result_q.xfer_len;
	assign out_ch.host_byte       = result_q.host_byte;
	assign out_ch.host_byte_valid = result_q.host_byte_valid;
	assign out_ch.rx_done         = result_q.rx_done;
	assign out_ch.tx_done         = result_q.tx_done;
	assign out_ch.phase           = result_q.phase;

	// A held event is never dropped while the result side stalls.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |=> valid_s1)
		else $error("held event lost");

	// A step always leaves a result to be offered.
	a_step_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("step without result");

	// An undelivered host byte reads as zero.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_q.host_byte_valid) |-> (result_q.host_byte == 8'd0))
		else $error("host byte set without delivery");

endmodule
